// File: hdl/chi_pkg.sv
package chi_pkg;

  localparam int MAX_KNOTS_DEF      = 64;
  localparam int MAX_COMPONENTS_DEF = 8;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_LOAD_TIME = 2'd0;
  localparam logic [1:0] OP_LOAD_VS   = 2'd1;
  localparam logic [1:0] OP_QUERY     = 2'd2;
  localparam logic [1:0] OP_RESERVED  = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_KNOT_COUNT      = 1'b0;
  localparam logic CFG_COMPONENT_COUNT = 1'b1;

  localparam logic [6:0] KNOT_COUNT_RESET      = 7'd2;
  localparam logic [3:0] COMPONENT_COUNT_RESET = 4'd1;

  localparam int         DIV_STEPS = 64;
  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  knot_index;
    logic [2:0]  comp_index;
    logic [31:0] word0;
    logic [31:0] word1;
  } item_t;

  typedef struct packed {
    logic [2:0]  component;
    logic [31:0] value;
    logic        out_of_domain;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [6:0] knot_count;
    logic [3:0] component_count;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD0,
    ST_RDL,
    ST_CHK,
    ST_SCAN,
    ST_DIVSET,
    ST_DIV,
    ST_SAT,
    ST_SQ,
    ST_CUBE,
    ST_BASIS,
    ST_G0,
    ST_G1,
    ST_CA,
    ST_CB,
    ST_CC,
    ST_CD,
    ST_CE,
    ST_EMIT,
    ST_ERR
  } state_t;

endpackage

// File: hdl/chi_fifo.sv
module chi_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] slots [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop) rptr <= ~rptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wptr] <= din;
  end

endmodule

// File: hdl/chi_front.sv
module chi_front import chi_pkg::*; #(
  parameter int MAX_KNOTS      = MAX_KNOTS_DEF,
  parameter int MAX_COMPONENTS = MAX_COMPONENTS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  item_t in_item,
  output item_t q_item,
  output logic  q_empty,
  input  logic  q_pop
);

  logic keep;

  // Unused codes and loads beyond the table are accepted and dropped here.
  always_comb begin
    unique case (in_item.op)
      OP_LOAD_TIME: keep = int'(in_item.knot_index) < MAX_KNOTS;
      OP_LOAD_VS:   keep = (int'(in_item.knot_index) < MAX_KNOTS) &&
                           (int'(in_item.comp_index) < MAX_COMPONENTS);
      OP_QUERY:     keep = 1'b1;
      default:      keep = 1'b0;
    endcase
  end

  chi_fifo #(.WIDTH($bits(item_t))) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push && keep),
    .din   (in_item),
    .full  (full),
    .pop   (q_pop),
    .dout  (q_item),
    .empty (q_empty)
  );

endmodule

// File: hdl/chi_back.sv
module chi_back import chi_pkg::*; #(
  parameter int MAX_KNOTS      = MAX_KNOTS_DEF,
  parameter int MAX_COMPONENTS = MAX_COMPONENTS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  item_t   q_item,
  input  logic    q_empty,
  output logic    q_pop,
  input  logic    r_full,
  output logic    r_push,
  output result_t r_item
);

  localparam int KW     = $clog2(MAX_KNOTS);
  localparam int CW     = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int VDEPTH = MAX_KNOTS * MAX_COMPONENTS;
  localparam int AW     = $clog2(VDEPTH);

  state_t state, state_next;

  logic [31:0] tmem [MAX_KNOTS];
  logic [31:0] vmem [VDEPTH];
  logic [31:0] smem [VDEPTH];
  logic [31:0] trd, vrd, srd;
  logic [KW-1:0] taddr;
  logic [AW-1:0] vaddr;
  logic [AW-1:0] waddr;

  logic [KW-1:0] mlast;
  logic [CW-1:0] nlast;

  logic [31:0] tq, prev, bt;
  logic [KW-1:0] kk;
  logic [CW-1:0] cc;
  logic [AW-1:0] lo_base, hi_base;
  logic [63:0] dsh, quo;
  logic [31:0] rem, hdiv;
  logic [5:0]  cnt;
  logic [30:0] s, s2, s3;
  logic signed [32:0] h00, h01, h10, h11, hreg;
  logic signed [33:0] g0, g1;
  logic signed [63:0] acc;
  logic [31:0] slo_r, shi_r;

  // Datapath helpers.
  logic        ood, hit, h_nonpos, div_done, ge;
  logic signed [32:0] d33, h33;
  logic [32:0] rem2;
  logic [61:0] psq;
  logic signed [32:0] b00, b10, b11;
  logic signed [65:0] pg;
  logic signed [64:0] pv;
  logic signed [65:0] ps;
  logic signed [47:0] rsh;
  logic [31:0] rsat;

  always_comb begin
    if (cfg.knot_count < 7'd2) mlast = KW'(1);
    else if (int'(cfg.knot_count) > MAX_KNOTS) mlast = KW'(MAX_KNOTS - 1);
    else mlast = KW'(int'(cfg.knot_count) - 1);
    if (cfg.component_count == 4'd0) nlast = '0;
    else if (int'(cfg.component_count) > MAX_COMPONENTS) nlast = CW'(MAX_COMPONENTS - 1);
    else nlast = CW'(int'(cfg.component_count) - 1);
  end

  always_comb begin
    ood      = ($signed(tq) < $signed(prev)) || ($signed(tq) > $signed(trd));
    hit      = ($signed(trd) > $signed(tq)) || (kk == mlast);
    d33      = $signed({tq[31], tq}) - $signed({prev[31], prev});
    h33      = $signed({bt[31], bt}) - $signed({prev[31], prev});
    h_nonpos = (h33 <= 33'sd0);
    rem2     = {rem, dsh[63]};
    ge       = (rem2 >= {1'b0, hdiv});
    div_done = (cnt == 6'(DIV_STEPS - 1));
    psq      = (state == ST_SQ) ? s * s : s2 * s;
    b00      = $signed({1'b0, s3, 1'b0}) - 33'sd3 * $signed({2'b00, s2})
               + $signed({2'b00, ONE_Q30});
    b10      = $signed({2'b00, s3}) - $signed({1'b0, s2, 1'b0}) + $signed({2'b00, s});
    b11      = $signed({2'b00, s3}) - $signed({2'b00, s2});
    pg       = ((state == ST_G0) ? h10 : h11) * hreg;
    pv       = $signed(vrd) * ((state == ST_CB) ? h00 : h01);
    ps       = (state == ST_CD) ? $signed(slo_r) * g0 : $signed(shi_r) * g1;
    rsh      = acc[63:16];
    if (rsh > 48'sd2147483647) rsat = 32'h7fff_ffff;
    else if (rsh < -48'sd2147483648) rsat = 32'h8000_0000;
    else rsat = rsh[31:0];
    waddr = AW'(int'(q_item.knot_index) * MAX_COMPONENTS + int'(q_item.comp_index));
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    r_push     = 1'b0;
    r_item     = '{component: 3'(cc), value: rsat, out_of_domain: 1'b0,
                   last: (cc == nlast)};
    taddr      = '0;
    vaddr      = lo_base + AW'(cc);
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_item.op == OP_QUERY) state_next = ST_RD0;
        end
      end
      ST_RD0: state_next = ST_RDL;
      ST_RDL: begin
        taddr      = mlast;
        state_next = ST_CHK;
      end
      ST_CHK: begin
        taddr      = KW'(1);
        state_next = ood ? ST_ERR : ST_SCAN;
      end
      ST_SCAN: begin
        taddr = kk + KW'(1);
        if (hit) state_next = ST_DIVSET;
      end
      ST_DIVSET: state_next = h_nonpos ? ST_SQ : ST_DIV;
      ST_DIV:    if (div_done) state_next = ST_SAT;
      ST_SAT:    state_next = ST_SQ;
      ST_SQ:     state_next = ST_CUBE;
      ST_CUBE:   state_next = ST_BASIS;
      ST_BASIS:  state_next = ST_G0;
      ST_G0:     state_next = ST_G1;
      ST_G1:     state_next = ST_CA;
      ST_CA:     state_next = ST_CB;
      ST_CB: begin
        vaddr      = hi_base + AW'(cc);
        state_next = ST_CC;
      end
      ST_CC: state_next = ST_CD;
      ST_CD: state_next = ST_CE;
      ST_CE: state_next = ST_EMIT;
      ST_EMIT: begin
        r_push = !r_full;
        if (!r_full) state_next = (cc == nlast) ? ST_IDLE : ST_CA;
      end
      ST_ERR: begin
        r_push = !r_full;
        r_item = '{component: 3'd0, value: 32'd0, out_of_domain: 1'b1, last: 1'b1};
        if (!r_full) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && !q_empty && q_item.op == OP_LOAD_TIME)
      tmem[KW'(q_item.knot_index)] <= q_item.word0;
    if (state == ST_IDLE && !q_empty && q_item.op == OP_LOAD_VS) begin
      vmem[waddr] <= q_item.word0;
      smem[waddr] <= q_item.word1;
    end
    trd <= tmem[taddr];
    vrd <= vmem[vaddr];
    srd <= smem[vaddr];
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        tq <= q_item.word0;
      end
      ST_RDL: prev <= trd;
      ST_CHK: kk <= KW'(1);
      ST_SCAN: begin
        if (hit) begin
          bt      <= trd;
          lo_base <= AW'((int'(kk) - 1) * MAX_COMPONENTS);
          hi_base <= AW'(int'(kk) * MAX_COMPONENTS);
        end else begin
          prev <= trd;
          kk   <= kk + KW'(1);
        end
      end
      ST_DIVSET: begin
        if (h_nonpos) begin
          s    <= '0;
          hreg <= '0;
        end else begin
          dsh  <= {{31{d33[32]}}, d33} << 30;
          rem  <= '0;
          quo  <= '0;
          hdiv <= h33[31:0];
          hreg <= h33;
          cnt  <= '0;
        end
      end
      ST_DIV: begin
        rem <= ge ? 32'(rem2 - {1'b0, hdiv}) : rem2[31:0];
        quo <= {quo[62:0], ge};
        dsh <= dsh << 1;
        cnt <= cnt + 6'd1;
      end
      ST_SAT:  s <= (quo > 64'(ONE_Q30)) ? ONE_Q30 : quo[30:0];
      ST_SQ:   s2 <= psq[60:30];
      ST_CUBE: s3 <= psq[60:30];
      ST_BASIS: begin
        h00 <= b00;
        h01 <= $signed({2'b00, ONE_Q30}) - b00;
        h10 <= b10;
        h11 <= b11;
        cc  <= '0;
      end
      ST_G0: g0 <= pg[63:30];
      ST_G1: g1 <= pg[63:30];
      ST_CB: begin
        acc   <= $signed(pv[63:0]) >>> 14;
        slo_r <= srd;
      end
      ST_CC: begin
        acc   <= acc + ($signed(pv[63:0]) >>> 14);
        shi_r <= srd;
      end
      ST_CD: acc <= acc + ps[63:0];
      ST_CE: acc <= acc + ps[63:0];
      ST_EMIT: if (!r_full && cc != nlast) cc <= cc + CW'(1);
      default: ;
    endcase
  end

endmodule

// File: hdl/cubic_hermite_interpolator_top.sv
// Cubic Hermite interpolator over a table of knots in Q16.16. Load
// transactions write a knot time, or one component's value and slope; they
// pass through the input queue and are written as the back end pops them. A
// query is popped and its end knots read and checked (ST_IDLE, ST_RD0,
// ST_RDL, ST_CHK); the knots are then scanned up to the first knot later
// than the query (at most knot_count - 1), the bit-serial normalizing divider
// runs (skipped for an empty interval), the basis weights are formed (ST_SQ
// to ST_G1), and each component gets its memory reads and the four
// multiply-adds, one multiplier a cycle. A query outside the knot range gives
// a single error result, pushed from ST_ERR after the range check once the
// result queue has room. The queue between front and back holds two
// transactions, and a two-entry result queue lets a result wait for pop.
module cubic_hermite_interpolator_top import chi_pkg::*; #(
  parameter int MAX_KNOTS      = MAX_KNOTS_DEF,
  parameter int MAX_COMPONENTS = MAX_COMPONENTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation,
  input  logic [5:0]  knot_index,
  input  logic [2:0]  component_index,
  input  logic signed [31:0] knot_time,
  input  logic signed [31:0] knot_value,
  input  logic signed [31:0] knot_slope,
  input  logic signed [31:0] query_time,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  component,
  output logic signed [31:0] value,
  output logic        out_of_domain,
  output logic        last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  cfg_t    cfg_r;
  item_t   in_item, q_item;
  logic    q_empty, q_pop;
  logic    r_full, r_push;
  result_t r_item, r_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_r <= '{knot_count: KNOT_COUNT_RESET, component_count: COMPONENT_COUNT_RESET};
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KNOT_COUNT:      cfg_r.knot_count <= cfg_data;
        CFG_COMPONENT_COUNT: cfg_r.component_count <= cfg_data[3:0];
      endcase
    end
  end

  // A query carries its time in the first data word.
  always_comb begin
    in_item.op         = operation;
    in_item.knot_index = knot_index;
    in_item.comp_index = component_index;
    in_item.word0      = (operation == OP_QUERY) ? query_time :
                         (operation == OP_LOAD_TIME) ? knot_time : knot_value;
    in_item.word1      = knot_slope;
  end

  chi_front #(.MAX_KNOTS(MAX_KNOTS), .MAX_COMPONENTS(MAX_COMPONENTS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_item  (q_item),
    .q_empty (q_empty),
    .q_pop   (q_pop)
  );

  chi_back #(.MAX_KNOTS(MAX_KNOTS), .MAX_COMPONENTS(MAX_COMPONENTS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_r),
    .q_item  (q_item),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .r_full  (r_full),
    .r_push  (r_push),
    .r_item  (r_item)
  );

  chi_fifo #(.WIDTH($bits(result_t))) u_results (
    .clk   (clk),
    .rst   (rst),
    .push  (r_push),
    .din   (r_item),
    .full  (r_full),
    .pop   (pop),
    .dout  (r_out),
    .empty (empty)
  );

  assign component     = r_out.component;
  assign value         = r_out.value;
  assign out_of_domain = r_out.out_of_domain;
  assign last          = r_out.last;

  a_push_room: assert property (@(posedge clk) disable iff (rst) r_push |-> !r_full)
    else $error("result pushed into a full queue");

  a_pop_avail: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("back end popped an empty queue");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_of_domain) |-> (last && value == 32'sd0 && component == 3'd0))
    else $error("malformed out-of-range result");

endmodule

// File: dv/tb_cubic_hermite_interpolator_top.sv
`timescale 1ns / 100ps

module tb_cubic_hermite_interpolator_top;
  import chi_pkg::*;

  localparam longint TMIN = -64'sd2147483648;
  localparam longint TMAX = 64'sd2147483647;

  class hermite_scoreboard;
    longint    knot_t[MAX_KNOTS_DEF];
    longint    knot_y[MAX_KNOTS_DEF * MAX_COMPONENTS_DEF];
    longint    knot_f[MAX_KNOTS_DEF * MAX_COMPONENTS_DEF];
    int        knots_raw;
    int        comps_raw;
    result_t   spline_q[$];
    int        mismatches;
    int        results_seen;
    int        queries;
    int        ood_queries;
    int        loads;

    function new();
      foreach (knot_t[k]) knot_t[k] = 0;
      foreach (knot_y[k]) begin
        knot_y[k] = 0;
        knot_f[k] = 0;
      end
      knots_raw = KNOT_COUNT_RESET;
      comps_raw = COMPONENT_COUNT_RESET;
      mismatches = 0;
      results_seen = 0;
      queries = 0;
      ood_queries = 0;
      loads = 0;
    endfunction

    function void write_reg(logic idx, logic [6:0] data);
      if (idx == CFG_KNOT_COUNT) knots_raw = data;
      else comps_raw = data[3:0];
    endfunction

    function int pending();
      return spline_q.size();
    endfunction

    // Works out the results of one accepted transaction.
    function void note_item(logic [1:0] op, logic [5:0] ki, logic [2:0] ci,
                            logic signed [31:0] kt, logic signed [31:0] kv,
                            logic signed [31:0] ks, logic signed [31:0] qt);
      int m, n, i;
      longint t, a, h, s, s2, s3, one, h00, h01, h10, h11, g0, g1, sum, r;
      bit [63:0] num, quo;
      result_t res;
      if (op == OP_LOAD_TIME) begin
        knot_t[ki] = kt;
        loads++;
        return;
      end
      if (op == OP_LOAD_VS) begin
        knot_y[ki * MAX_COMPONENTS_DEF + ci] = kv;
        knot_f[ki * MAX_COMPONENTS_DEF + ci] = ks;
        loads++;
        return;
      end
      if (op != OP_QUERY) return;
      queries++;
      m = knots_raw < 2 ? 2 : (knots_raw > MAX_KNOTS_DEF ? MAX_KNOTS_DEF : knots_raw);
      n = comps_raw < 1 ? 1 : (comps_raw > MAX_COMPONENTS_DEF ? MAX_COMPONENTS_DEF : comps_raw);
      t = qt;
      if (t < knot_t[0] || t > knot_t[m-1]) begin
        ood_queries++;
        res.component = 0;
        res.value = 0;
        res.out_of_domain = 1'b1;
        res.last = 1'b1;
        spline_q = {spline_q, res};
        return;
      end
      i = m - 1;
      for (int k = 1; k < m; k++)
        if (knot_t[k] > t) begin
          i = k;
          break;
        end
      a = knot_t[i-1];
      h = knot_t[i] - a;
      one = 64'sd1 << 30;
      s = 0;
      if (h > 0) begin
        num = 64'(t - a) << 30;
        quo = num / 64'(h);
        s = (quo > 64'(one)) ? one : longint'(quo);
      end else begin
        h = 0;
      end
      s2 = (s * s) >>> 30;
      s3 = (s2 * s) >>> 30;
      h00 = 2 * s3 - 3 * s2 + one;
      h01 = one - h00;
      h10 = s3 - 2 * s2 + s;
      h11 = s3 - s2;
      g0 = (h10 * h) >>> 30;
      g1 = (h11 * h) >>> 30;
      for (int k = 0; k < n; k++) begin
        sum = ((knot_y[(i-1) * MAX_COMPONENTS_DEF + k] * h00) >>> 14)
            + ((knot_y[i * MAX_COMPONENTS_DEF + k] * h01) >>> 14)
            + knot_f[(i-1) * MAX_COMPONENTS_DEF + k] * g0
            + knot_f[i * MAX_COMPONENTS_DEF + k] * g1;
        r = sum >>> 16;
        if (r > TMAX) r = TMAX;
        if (r < TMIN) r = TMIN;
        res.component = 3'(k);
        res.value = 32'(r);
        res.out_of_domain = 1'b0;
        res.last = (k + 1 == n);
        spline_q = {spline_q, res};
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      results_seen++;
      if (spline_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result comp=%0d value=%0h ood=%0b last=%0b",
                   $realtime, got.component, got.value, got.out_of_domain, got.last);
        return;
      end
      want = spline_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp comp=%0d value=%0h ood=%0b last=%0b, got comp=%0d value=%0h ood=%0b last=%0b",
                   $realtime, want.component, want.value, want.out_of_domain, want.last,
                   got.component, got.value, got.out_of_domain, got.last);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [1:0]  operation;
  logic [5:0]  knot_index;
  logic [2:0]  component_index;
  logic signed [31:0] knot_time;
  logic signed [31:0] knot_value;
  logic signed [31:0] knot_slope;
  logic signed [31:0] query_time;
  logic        empty;
  logic        pop;
  logic [2:0]  component;
  logic signed [31:0] value;
  logic        out_of_domain;
  logic        last;
  logic        cfg_we;
  logic        cfg_index;
  logic [6:0]  cfg_data;

  hermite_scoreboard sb;
  bit     tx_idle_en;
  bit     rx_idle_en;
  int     rx_hold;
  longint ktab[MAX_KNOTS_DEF];
  int     cur_m;
  int     cur_n;

  cubic_hermite_interpolator_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .operation(operation),
    .knot_index(knot_index), .component_index(component_index),
    .knot_time(knot_time), .knot_value(knot_value), .knot_slope(knot_slope),
    .query_time(query_time), .empty(empty), .pop(pop), .component(component),
    .value(value), .out_of_domain(out_of_domain), .last(last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("[cubic_hermite_interpolator_top] ERROR");
    $finish;
  end

  // Receiver: random pop, with an optional long hold-off counted here.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (rx_hold > 0) begin
      pop <= 1'b0;
      rx_hold--;
    end else begin
      pop <= !(rx_idle_en && $urandom_range(99) < 31);
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty)
      sb.check_result('{component, value, out_of_domain, last});
  end

  // Leaves push high on return; the caller lowers it when the stream ends.
  task automatic push_item(logic [1:0] op, logic [5:0] ki, logic [2:0] ci,
                           logic [31:0] kt, logic [31:0] kv, logic [31:0] ks,
                           logic [31:0] qt);
    while (tx_idle_en && $urandom_range(99) < 31) begin
      push <= 1'b0;
      @(negedge clk);
    end
    operation <= op;
    knot_index <= ki;
    component_index <= ci;
    knot_time <= kt;
    knot_value <= kv;
    knot_slope <= ks;
    query_time <= qt;
    push <= 1'b1;
    do @(posedge clk); while (full);
    sb.note_item(op, ki, ci, kt, kv, ks, qt);
    @(negedge clk);
  endtask

  task automatic query(longint t);
    push_item(OP_QUERY, 6'($urandom), 3'($urandom), $urandom, $urandom, $urandom, 32'(t));
  endtask

  // Called at a falling edge right after the last transaction went in.
  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // Loads may still sit in the input queue after the last result.
    repeat (20) @(negedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [6:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  function automatic longint pick(longint lo, longint hi);
    longint unsigned span;
    span = longint'(hi - lo) + 1;
    return lo + longint'({$urandom, $urandom} % span);
  endfunction

  // mode 0: wide sorted times, 1: narrow ascending, 2: unsorted, with a repeat if m > 2.
  task automatic load_table(int m, int n, int mode);
    int q[$];
    for (int k = 0; k < m; k++) q = {q, int'($urandom)};
    if (mode == 0) q.sort();
    for (int k = 0; k < m; k++) begin
      if (mode == 1)
        ktab[k] = (k == 0) ? pick(-(64'sd1 << 24), 64'sd1 << 24)
                           : ktab[k-1] + $urandom_range(1, 1 << 18);
      else
        ktab[k] = q[k];
    end
    if (mode == 2 && m > 2) ktab[1] = ktab[0];
    cur_m = m;
    cur_n = n;
    for (int k = 0; k < m; k++) begin
      push_item(OP_LOAD_TIME, 6'(k), 3'($urandom), 32'(ktab[k]), $urandom, $urandom,
                $urandom);
      for (int c = 0; c < n; c++)
        push_item(OP_LOAD_VS, 6'(k), 3'(c), $urandom, $urandom, $urandom, $urandom);
      if ($urandom_range(9) == 0)
        push_item(OP_RESERVED, 6'($urandom), 3'($urandom), $urandom, $urandom, $urandom,
                  $urandom);
    end
  endtask

  task automatic random_queries(int count);
    int     sel, k;
    longint lo, hi;
    for (int j = 0; j < count; j++) begin
      sel = $urandom_range(99);
      k = $urandom_range(cur_m - 2);
      if (sel < 12) begin
        query(ktab[$urandom_range(cur_m - 1)]);
      end else if (sel < 22 && ktab[0] > TMIN) begin
        query(pick(TMIN, ktab[0] - 1));
      end else if (sel < 30 && ktab[cur_m-1] < TMAX) begin
        query(pick(ktab[cur_m-1] + 1, TMAX));
      end else begin
        lo = ktab[k];
        hi = ktab[k+1];
        query(hi > lo ? pick(lo, hi) : lo);
      end
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    push = 1'b0;
    operation = OP_LOAD_TIME;
    knot_index = '0;
    component_index = '0;
    knot_time = '0;
    knot_value = '0;
    knot_slope = '0;
    query_time = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_KNOT_COUNT;
    cfg_data = '0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    rx_hold = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset configuration, knots at the extremes of time.
    ktab[0] = TMIN;
    ktab[1] = TMAX;
    cur_m = 2;
    cur_n = 1;
    push_item(OP_LOAD_TIME, 6'd0, 3'd0, 32'h8000_0000, '0, '0, '0);
    push_item(OP_LOAD_TIME, 6'd1, 3'd0, 32'h7fff_ffff, '0, '0, '0);
    push_item(OP_LOAD_VS, 6'd0, 3'd0, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, '0);
    push_item(OP_LOAD_VS, 6'd1, 3'd0, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, '0);
    query(TMIN);
    query(TMAX);
    query(0);
    query(-1);
    push_item(OP_RESERVED, 6'h3f, 3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              32'hffff_ffff);
    push_item(OP_LOAD_VS, 6'd0, 3'd0, '0, 32'h7fff_ffff, 32'h7fff_ffff, '0);
    push_item(OP_LOAD_VS, 6'd1, 3'd0, '0, 32'h7fff_ffff, 32'h7fff_ffff, '0);
    query(pick(TMIN, TMAX));
    query(pick(TMIN, TMAX));
    // An empty interval, and queries just outside it on both sides.
    push_item(OP_LOAD_TIME, 6'd0, 3'd0, 32'h0005_0000, '0, '0, '0);
    push_item(OP_LOAD_TIME, 6'd1, 3'd0, 32'h0005_0000, '0, '0, '0);
    query(64'h5_0000);
    query(64'h4_ffff);
    query(64'h5_0001);
    drain();

    // Register values below the usable range are clamped up.
    write_cfg(CFG_KNOT_COUNT, 7'd0);
    write_cfg(CFG_COMPONENT_COUNT, 7'd0);
    ktab[0] = 64'h5_0000;
    ktab[1] = 64'h5_0000;
    query(64'h5_0000);
    query(0);
    drain();

    // A longer table, with a long receiver hold-off so the block backs up.
    write_cfg(CFG_KNOT_COUNT, 7'd24);
    write_cfg(CFG_COMPONENT_COUNT, 7'd1);
    load_table(24, 1, 1);
    rx_hold = 1000;
    random_queries(14);
    drain();

    // A stretch with no idling on either side; the component count is clamped down.
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    write_cfg(CFG_KNOT_COUNT, 7'd3);
    write_cfg(CFG_COMPONENT_COUNT, 7'h0f);
    load_table(3, 8, 0);
    random_queries(12);
    drain();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    while (sb.loads + sb.queries < 150) begin
      cur_m = $urandom_range(2, 6);
      cur_n = $urandom_range(1, 4);
      write_cfg(CFG_KNOT_COUNT, 7'(cur_m));
      write_cfg(CFG_COMPONENT_COUNT, 7'(cur_n));
      load_table(cur_m, cur_n, $urandom_range(2));
      random_queries($urandom_range(6, 10));
      drain();
    end

    repeat (50) @(posedge clk);
    $display("Covered %0d loads and %0d queries (%0d out of range); %0d results checked.",
             sb.loads, sb.queries, sb.ood_queries, sb.results_seen);
    $display("Tables of 2 to 24 knots, 1 to 8 components, clamped counts, extreme times, empty intervals.");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[cubic_hermite_interpolator_top] OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.pending());
      $display("[cubic_hermite_interpolator_top] ERROR");
    end
    $finish;
  end

endmodule
